[rtl/psr_pkg.sv]
`timescale 1ns / 1ps

package psr_pkg;

    localparam int PORTS_DEF   = 8;
    localparam int ONTS_DEF    = 32;
    localparam int RECORDS_DEF = 8;

    localparam logic [1:0] ACT_ADD       = 2'd0;
    localparam logic [1:0] ACT_READ_ALL  = 2'd1;
    localparam logic [1:0] ACT_FIND_STAT = 2'd2;
    localparam logic [1:0] ACT_FIND_TIME = 2'd3;

    localparam logic [1:0] RC_OK        = 2'd0;
    localparam logic [1:0] RC_BAD_PORT  = 2'd1;
    localparam logic [1:0] RC_BAD_ONT   = 2'd2;
    localparam logic [1:0] RC_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  port_num;
        logic [5:0]  ont_num;
        logic [63:0] serial_text;
        logic [63:0] equipment_id;
        logic [63:0] firmware_text;
        logic [31:0] up_time;
        logic [31:0] down_time;
        logic [3:0]  conn_status;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  result_code;
        logic [63:0] out_serial;
        logic [63:0] out_equipment;
        logic [63:0] out_firmware;
        logic [31:0] out_up_time;
        logic [31:0] out_down_time;
        logic [3:0]  out_status;
        logic        last;
    } t_out_rsp;

    typedef struct packed {
        logic [63:0] serial;
        logic [63:0] equipment;
        logic [63:0] firmware;
        logic [31:0] up_time;
        logic [31:0] down_time;
        logic [3:0]  status;
    } t_rec;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_DATA,
        S_RESP
    } t_state;

    // keep bytes up to the first zero byte
    function automatic logic [63:0] clip_text(input logic [63:0] v);
        logic [63:0] kept;
        logic        live;
        kept = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (v[8*b +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                kept[8*b +: 8] = v[8*b +: 8];
            end
        end
        return kept;
    endfunction

endpackage

[rtl/per_slot_event_ring_with_search_unit.sv]
`timescale 1ns / 1ps
// A request is taken in S_IDLE; a range error goes straight to S_RESP, any other reads its
//   slot in S_SLOT. An add writes its record there and answers from S_RESP; read all and the
//   finds read records one by one in S_DATA via the single record read port; a find that
//   misses or meets an empty ring answers from S_RESP. One request at a time: the next is
//   taken once the last result is registered; output stalls hold the sequencer. Reset is
//   synchronous, active low; a clearing pass then zeroes both stores, taking no request.
module per_slot_event_ring_with_search_unit #(
    parameter int PORTS         = psr_pkg::PORTS_DEF,
    parameter int ONTS_PER_PORT = psr_pkg::ONTS_DEF,
    parameter int RECORDS       = psr_pkg::RECORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  psr_pkg::t_in_req   i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output psr_pkg::t_out_rsp  o_out_rsp
);

    localparam int SLOTS   = PORTS * ONTS_PER_PORT;
    localparam int ENTRIES = SLOTS * RECORDS;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CNT_W   = $clog2(RECORDS + 1);
    localparam int SM_W    = IDX_W + CNT_W;
    localparam int REC_W   = $bits(psr_pkg::t_rec);

    // state
    psr_pkg::t_state   r_state, n_state;
    psr_pkg::t_in_req  r_req, n_req;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [1:0]        r_code, n_code;
    logic [ENT_W-1:0]  r_clr, n_clr;
    logic              r_out_valid, n_out_valid;
    psr_pkg::t_out_rsp r_out, n_out;

    // memory ports
    logic              rec_we, rec_re, slot_we, slot_re;
    logic [ENT_W-1:0]  rec_waddr, rec_raddr;
    logic [SLOT_W-1:0] slot_waddr, slot_raddr;
    psr_pkg::t_rec     rec_wdata, rec_rdata;
    logic [REC_W-1:0]  rec_rvec;
    logic [SM_W-1:0]   slot_wdata, slot_rdata;

    // lookup helpers
    logic [10:0]       slot_wide;
    logic [16:0]       ent_wide;
    logic [IDX_W-1:0]  cur_wp, nxt_wp;
    logic [CNT_W-1:0]  cur_fill, nxt_fill;
    logic [IDX_W-1:0]  ent_off;
    logic              out_free, hit;

    psr_ram #(.DEPTH(ENTRIES), .AW(ENT_W), .DW(REC_W)) u_rec (
        .i_clk  (i_clk),
        .i_we   (rec_we),
        .i_waddr(rec_waddr),
        .i_wdata(rec_wdata),
        .i_re   (rec_re),
        .i_raddr(rec_raddr),
        .o_rdata(rec_rvec)
    );
    assign rec_rdata = psr_pkg::t_rec'(rec_rvec);

    psr_ram #(.DEPTH(SLOTS), .AW(SLOT_W), .DW(SM_W)) u_slot (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_re   (slot_re),
        .i_raddr(slot_raddr),
        .o_rdata(slot_rdata)
    );

    assign cur_wp   = slot_rdata[SM_W-1:CNT_W];
    assign cur_fill = slot_rdata[CNT_W-1:0];
    assign nxt_wp   = (32'(cur_wp) == RECORDS - 1) ? '0 : IDX_W'(cur_wp + 1'b1);
    assign nxt_fill = (32'(cur_fill) < RECORDS) ? CNT_W'(cur_fill + 1'b1) : cur_fill;

    // slot = port*ONTS_PER_PORT + terminal; entry = slot*RECORDS + offset
    assign slot_wide = 11'(i_in_req.port_num) * 11'(ONTS_PER_PORT) + 11'(i_in_req.ont_num);
    assign ent_wide  = 17'(r_slot) * 17'(RECORDS) + 17'(ent_off);

    // the one compare unit used for both find actions
    assign hit = (r_req.action == psr_pkg::ACT_FIND_STAT)
               ? (rec_rdata.status == r_req.conn_status)
               : (rec_rdata.up_time >= r_req.up_time);

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psr_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_req  <= n_req;
        r_slot <= n_slot;
        r_idx  <= n_idx;
        r_fill <= n_fill;
        r_code <= n_code;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_code      = r_code;
        n_clr       = r_clr;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        ent_off     = r_idx;
        rec_we      = 1'b0;
        rec_re      = 1'b0;
        slot_we     = 1'b0;
        slot_re     = 1'b0;
        rec_waddr   = r_clr;
        rec_wdata   = '0;
        slot_waddr  = r_clr[SLOT_W-1:0];
        slot_wdata  = '0;
        slot_raddr  = slot_wide[SLOT_W-1:0];
        rec_raddr   = ent_wide[ENT_W-1:0];

        case (r_state)
            psr_pkg::S_CLEAR: begin
                rec_we  = 1'b1;
                slot_we = (32'(r_clr) < SLOTS);
                if (32'(r_clr) == ENTRIES - 1) begin
                    n_state = psr_pkg::S_IDLE;
                end else begin
                    n_clr = ENT_W'(r_clr + 1'b1);
                end
            end
            psr_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_req  = i_in_req;
                    n_slot = slot_wide[SLOT_W-1:0];
                    n_idx  = '0;
                    if (32'(i_in_req.port_num) >= PORTS) begin
                        n_code  = psr_pkg::RC_BAD_PORT;
                        n_state = psr_pkg::S_RESP;
                    end else if (32'(i_in_req.ont_num) >= ONTS_PER_PORT) begin
                        n_code  = psr_pkg::RC_BAD_ONT;
                        n_state = psr_pkg::S_RESP;
                    end else begin
                        slot_re = 1'b1;
                        n_state = psr_pkg::S_SLOT;
                    end
                end
            end
            psr_pkg::S_SLOT: begin
                n_fill = cur_fill;
                case (r_req.action)
                    psr_pkg::ACT_ADD: begin
                        ent_off   = cur_wp;
                        rec_we    = 1'b1;
                        rec_waddr = ent_wide[ENT_W-1:0];
                        rec_wdata.serial    = psr_pkg::clip_text(r_req.serial_text);
                        rec_wdata.equipment = psr_pkg::clip_text(r_req.equipment_id);
                        rec_wdata.firmware  = psr_pkg::clip_text(r_req.firmware_text);
                        rec_wdata.up_time   = r_req.up_time;
                        rec_wdata.down_time = r_req.down_time;
                        rec_wdata.status    = r_req.conn_status;
                        slot_we    = 1'b1;
                        slot_waddr = r_slot;
                        slot_wdata = {nxt_wp, nxt_fill};
                        n_code     = psr_pkg::RC_OK;
                        n_state    = psr_pkg::S_RESP;
                    end
                    psr_pkg::ACT_READ_ALL: begin
                        rec_re  = 1'b1;
                        n_state = psr_pkg::S_DATA;
                    end
                    default: begin
                        if (cur_fill == '0) begin
                            n_code  = psr_pkg::RC_NOT_FOUND;
                            n_state = psr_pkg::S_RESP;
                        end else begin
                            rec_re  = 1'b1;
                            n_state = psr_pkg::S_DATA;
                        end
                    end
                endcase
            end
            psr_pkg::S_DATA: begin
                ent_off = IDX_W'(r_idx + 1'b1);
                if (r_req.action == psr_pkg::ACT_READ_ALL) begin
                    if (out_free) begin
                        n_out_valid         = 1'b1;
                        n_out.result_code   = psr_pkg::RC_OK;
                        n_out.out_serial    = rec_rdata.serial;
                        n_out.out_equipment = rec_rdata.equipment;
                        n_out.out_firmware  = rec_rdata.firmware;
                        n_out.out_up_time   = rec_rdata.up_time;
                        n_out.out_down_time = rec_rdata.down_time;
                        n_out.out_status    = rec_rdata.status;
                        n_out.last          = (32'(r_idx) == RECORDS - 1);
                        if (32'(r_idx) == RECORDS - 1) begin
                            n_state = psr_pkg::S_IDLE;
                        end else begin
                            n_idx  = IDX_W'(r_idx + 1'b1);
                            rec_re = 1'b1;
                        end
                    end
                end else if (hit) begin
                    if (out_free) begin
                        n_out_valid         = 1'b1;
                        n_out.result_code   = psr_pkg::RC_OK;
                        n_out.out_serial    = rec_rdata.serial;
                        n_out.out_equipment = rec_rdata.equipment;
                        n_out.out_firmware  = rec_rdata.firmware;
                        n_out.out_up_time   = rec_rdata.up_time;
                        n_out.out_down_time = rec_rdata.down_time;
                        n_out.out_status    = rec_rdata.status;
                        n_out.last          = 1'b1;
                        n_state             = psr_pkg::S_IDLE;
                    end
                end else if (CNT_W'(r_idx) + 1'b1 == r_fill) begin
                    n_code  = psr_pkg::RC_NOT_FOUND;
                    n_state = psr_pkg::S_RESP;
                end else begin
                    n_idx  = IDX_W'(r_idx + 1'b1);
                    rec_re = 1'b1;
                end
            end
            psr_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.result_code = r_code;
                    n_out.last        = 1'b1;
                    n_state           = psr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = psr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

[rtl/psr_ram.sv]
`timescale 1ns / 1ps

module psr_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[verif/tb_per_slot_event_ring_with_search_unit.sv]
`timescale 1ns / 1ps

module tb_per_slot_event_ring_with_search_unit;

    localparam int PORTS_N   = psr_pkg::PORTS_DEF;
    localparam int ONTS_N    = psr_pkg::ONTS_DEF;
    localparam int RECS_N    = psr_pkg::RECORDS_DEF;
    localparam int SLOTS_N   = PORTS_N * ONTS_N;
    // clearing pass after reset plus generous margin for stalls
    localparam int IDLE_LIMIT = SLOTS_N * RECS_N + 20000;
    localparam int HOLD_LONG  = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    psr_pkg::t_in_req   i_in_req;
    logic               o_out_valid;
    logic               i_out_stall;
    psr_pkg::t_out_rsp  o_out_rsp;

    per_slot_event_ring_with_search_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the event store, updated as each request is taken
    // ---------------------------------------------------------------
    psr_pkg::t_rec shadow_rec [SLOTS_N * RECS_N];
    logic [2:0]    shadow_wp  [SLOTS_N];
    logic [3:0]    shadow_fill[SLOTS_N];

    psr_pkg::t_in_req  pending_reqs[$];   // requests waiting for the driver
    psr_pkg::t_out_rsp expected_rsps[$];  // results owed by the block
    int                n_errors;
    int                idle_cycles;

    // text keeps bytes up to the first NUL, low byte first
    function automatic logic [63:0] trim_text(input logic [63:0] v);
        logic [63:0] r;
        int          b;
        r = '0;
        for (b = 0; b < 8; b++) begin
            if (v[8*b +: 8] == 8'd0) break;
            r[8*b +: 8] = v[8*b +: 8];
        end
        return r;
    endfunction

    function automatic psr_pkg::t_out_rsp make_rsp(input logic [1:0] code,
                                                   input psr_pkg::t_rec r,
                                                   input logic fin);
        psr_pkg::t_out_rsp o;
        o.result_code   = code;
        o.out_serial    = r.serial;
        o.out_equipment = r.equipment;
        o.out_firmware  = r.firmware;
        o.out_up_time   = r.up_time;
        o.out_down_time = r.down_time;
        o.out_status    = r.status;
        o.last          = fin;
        return o;
    endfunction

    // apply one request to the shadow store and queue its results
    task automatic predict_store(input psr_pkg::t_in_req q);
        int            slot;
        int            base;
        int            i;
        int            n;
        bit            hit;
        psr_pkg::t_rec blank;
        psr_pkg::t_rec r;
        blank = '0;
        if (q.port_num >= PORTS_N) begin
            expected_rsps.push_back(make_rsp(psr_pkg::RC_BAD_PORT, blank, 1'b1));
            return;
        end
        if (q.ont_num >= ONTS_N) begin
            expected_rsps.push_back(make_rsp(psr_pkg::RC_BAD_ONT, blank, 1'b1));
            return;
        end
        slot = q.port_num * ONTS_N + q.ont_num;
        base = slot * RECS_N;
        case (q.action)
            psr_pkg::ACT_ADD: begin
                r.serial    = trim_text(q.serial_text);
                r.equipment = trim_text(q.equipment_id);
                r.firmware  = trim_text(q.firmware_text);
                r.up_time   = q.up_time;
                r.down_time = q.down_time;
                r.status    = q.conn_status;
                shadow_rec[base + shadow_wp[slot]] = r;
                shadow_wp[slot] = 3'((shadow_wp[slot] + 1) % RECS_N);
                if (shadow_fill[slot] < RECS_N) shadow_fill[slot]++;
                expected_rsps.push_back(make_rsp(psr_pkg::RC_OK, blank, 1'b1));
            end
            psr_pkg::ACT_READ_ALL: begin
                for (i = 0; i < RECS_N; i++)
                    expected_rsps.push_back(make_rsp(psr_pkg::RC_OK, shadow_rec[base + i],
                                                     i == RECS_N - 1));
            end
            default: begin
                n   = shadow_fill[slot];
                hit = 1'b0;
                for (i = 0; i < n && !hit; i++) begin
                    r = shadow_rec[base + i];
                    if (q.action == psr_pkg::ACT_FIND_STAT ? (r.status == q.conn_status)
                                                           : (r.up_time >= q.up_time)) begin
                        hit = 1'b1;
                        expected_rsps.push_back(make_rsp(psr_pkg::RC_OK, r, 1'b1));
                    end
                end
                if (!hit)
                    expected_rsps.push_back(make_rsp(psr_pkg::RC_NOT_FOUND, blank, 1'b1));
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus build
    // ---------------------------------------------------------------
    function automatic logic [63:0] rand_text();
        logic [63:0] v;
        int          cut;
        v   = {$urandom, $urandom};
        cut = $urandom_range(0, 9);
        // sometimes plant a NUL to exercise truncation
        if (cut < 8) v[8*cut +: 8] = 8'd0;
        return v;
    endfunction

    function automatic psr_pkg::t_in_req build_req(input logic [1:0] act, input int port,
                                                   input int ont);
        psr_pkg::t_in_req q;
        q.action        = act;
        q.port_num      = 4'(port);
        q.ont_num       = 6'(ont);
        q.serial_text   = rand_text();
        q.equipment_id  = rand_text();
        q.firmware_text = rand_text();
        q.up_time       = $urandom;
        q.down_time     = $urandom;
        q.conn_status   = 4'($urandom_range(0, 15));
        return q;
    endfunction

    task automatic queue_directed();
        psr_pkg::t_in_req q;
        int               k;
        // read an empty slot, finds on an empty slot
        pending_reqs.push_back(build_req(psr_pkg::ACT_READ_ALL, 0, 0));
        pending_reqs.push_back(build_req(psr_pkg::ACT_FIND_STAT, 0, 0));
        pending_reqs.push_back(build_req(psr_pkg::ACT_FIND_TIME, 0, 0));
        // range errors: bad port, both bad, then bad terminal
        pending_reqs.push_back(build_req(psr_pkg::ACT_ADD, 15, 0));
        pending_reqs.push_back(build_req(psr_pkg::ACT_READ_ALL, PORTS_N, 63));
        pending_reqs.push_back(build_req(psr_pkg::ACT_FIND_TIME, 7, ONTS_N));
        pending_reqs.push_back(build_req(psr_pkg::ACT_ADD, 0, 63));
        // fill highest slot past wrap, all-ones and all-zero fields
        for (k = 0; k < RECS_N + 2; k++) begin
            q = build_req(psr_pkg::ACT_ADD, PORTS_N - 1, ONTS_N - 1);
            if (k == 0) begin
                q.serial_text = '1; q.equipment_id = '1; q.firmware_text = '1;
                q.up_time = '1; q.down_time = '1; q.conn_status = 4'hF;
            end
            if (k == 1) begin
                q.serial_text = '0; q.equipment_id = '0; q.firmware_text = '0;
                q.up_time = '0; q.down_time = '0; q.conn_status = 4'h0;
            end
            pending_reqs.push_back(q);
        end
        pending_reqs.push_back(build_req(psr_pkg::ACT_READ_ALL, PORTS_N - 1, ONTS_N - 1));
        q = build_req(psr_pkg::ACT_FIND_TIME, PORTS_N - 1, ONTS_N - 1);
        q.up_time = '0;
        pending_reqs.push_back(q);
        q.up_time = '1;
        pending_reqs.push_back(q);
        q = build_req(psr_pkg::ACT_FIND_STAT, PORTS_N - 1, ONTS_N - 1);
        q.conn_status = 4'hF;
        pending_reqs.push_back(q);
    endtask

    task automatic queue_random(input int count);
        psr_pkg::t_in_req q;
        int               k;
        int               pick;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                // a few hot slots so rings fill and wrap
                q = build_req(2'($urandom_range(0, 3)), $urandom_range(0, 1),
                              $urandom_range(0, 2));
                if (pick < 10) q.up_time = $urandom_range(0, 3) << 30;
            end else begin
                q = build_req(2'($urandom_range(0, 3)), $urandom_range(0, 15),
                              $urandom_range(0, 63));
            end
            pending_reqs.push_back(q);
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts with random gaps, payload held while stalled
    // ---------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (i_in_valid && o_in_stall) begin
            // hold request
        end else begin
            if (i_in_valid) begin
                predict_store(i_in_req);
                void'(pending_reqs.pop_front());
            end
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 12);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_in_req   <= pending_reqs[0];
                i_in_valid <= 1'b1;
                burst_left <= burst_left - 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver stall pattern: phases of none, random, and one long hold-off
    // ---------------------------------------------------------------
    int stall_mode;
    int stall_left;
    bit long_hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall    <= 1'b0;
            stall_mode     <= 0;
            stall_left     <= 0;
            long_hold_done <= 1'b0;
        end else if (stall_left == 0) begin
            if (!long_hold_done && pending_reqs.size() < 100) begin
                stall_mode     <= 2;
                stall_left     <= HOLD_LONG;
                long_hold_done <= 1'b1;
                i_out_stall    <= 1'b1;
            end else begin
                stall_mode  <= $urandom_range(0, 1);
                stall_left  <= $urandom_range(20, 120);
                i_out_stall <= 1'b0;
            end
        end else begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_mode == 2) ? 1'b1 :
                           (stall_mode == 1) ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each taken result with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        psr_pkg::t_out_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_out_rsp.result_code), 64'd0);
            end else begin
                want = expected_rsps.pop_front();
                if (o_out_rsp.result_code !== want.result_code)
                    report_mismatch("result_code", 64'(o_out_rsp.result_code),
                                    64'(want.result_code));
                if (o_out_rsp.out_serial !== want.out_serial)
                    report_mismatch("out_serial", o_out_rsp.out_serial, want.out_serial);
                if (o_out_rsp.out_equipment !== want.out_equipment)
                    report_mismatch("out_equipment", o_out_rsp.out_equipment,
                                    want.out_equipment);
                if (o_out_rsp.out_firmware !== want.out_firmware)
                    report_mismatch("out_firmware", o_out_rsp.out_firmware,
                                    want.out_firmware);
                if (o_out_rsp.out_up_time !== want.out_up_time)
                    report_mismatch("out_up_time", 64'(o_out_rsp.out_up_time),
                                    64'(want.out_up_time));
                if (o_out_rsp.out_down_time !== want.out_down_time)
                    report_mismatch("out_down_time", 64'(o_out_rsp.out_down_time),
                                    64'(want.out_down_time));
                if (o_out_rsp.out_status !== want.out_status)
                    report_mismatch("out_status", 64'(o_out_rsp.out_status),
                                    64'(want.out_status));
                if (o_out_rsp.last !== want.last)
                    report_mismatch("last", 64'(o_out_rsp.last), 64'(want.last));
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb_per_slot_event_ring_with_search_unit: done, errors");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n = 1'b0;
        for (k = 0; k < SLOTS_N * RECS_N; k++) shadow_rec[k] = '0;
        for (k = 0; k < SLOTS_N; k++) begin
            shadow_wp[k]   = '0;
            shadow_fill[k] = '0;
        end
        queue_directed();
        queue_random(100);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait for every request to go in and every result to come out
        wait (pending_reqs.size() == 0 && !i_in_valid);
        wait (expected_rsps.size() == 0);
        repeat (RECS_N + 20) @(posedge i_clk);
        if (n_errors == 0 && expected_rsps.size() == 0)
            $display("tb_per_slot_event_ring_with_search_unit: done, clean");
        else
            $display("tb_per_slot_event_ring_with_search_unit: done, errors");
        $finish;
    end

endmodule

[per_slot_event_ring_with_search_unit.f]
rtl/psr_pkg.sv
rtl/psr_ram.sv
rtl/per_slot_event_ring_with_search_unit.sv
verif/tb_per_slot_event_ring_with_search_unit.sv
